[rtl/caller_id_fsk_message_parser_unit_defines.svh]
// Assertion macros shared by the caller-ID parser modules.
`ifndef CALLER_ID_FSK_MESSAGE_PARSER_UNIT_DEFINES_SVH
`define CALLER_ID_FSK_MESSAGE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define CIDP_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset.
`define CIDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cidp_pkg.sv]
// Types and constants shared by the caller-ID message parser modules.
package cidp_pkg;

    localparam logic [7:0] SYNC_BYTE_A   = 8'h55;
    localparam logic [7:0] SYNC_BYTE_B   = 8'hAA;
    localparam logic [7:0] FMT_SDMF      = 8'h04;
    localparam logic [7:0] FMT_MDMF      = 8'h80;
    localparam logic [7:0] SDMF_MIN_LEN  = 8'd9;
    localparam logic [7:0] MDMF_MIN_LEN  = 8'd13;
    localparam logic [7:0] SDMF_TIME_LEN = 8'd8;
    localparam logic [3:0] SDMF_SKIP     = 4'd8;
    localparam logic [3:0] MDMF_SKIP     = 4'd11;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] RST_SEARCH_WINDOW = 8'd118;
    localparam logic [3:0] RST_SYNC_RUN_MIN  = 4'd10;
    localparam logic [7:0] RST_MAX_DIGITS    = 8'd32;

    typedef enum logic [1:0] {
        CFG_SEARCH_WINDOW = 2'd0,
        CFG_SYNC_RUN_MIN  = 2'd1,
        CFG_MAX_DIGITS    = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_DIGIT = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] search_window;
        logic [3:0] sync_run_min;
        logic [7:0] max_digits;
    } t_cfg;

    // One classified byte as it travels from the front end to the parser.
    typedef struct packed {
        logic       start;
        logic [7:0] data;
        logic       is_sync;
        logic       is_fmt;
        logic       fmt_multi;
    } t_item;

endpackage

[rtl/cidp_front.sv]
// Front end: takes received bytes and tags sync and format bytes.
module cidp_front
    import cidp_pkg::*;
(
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_start,
    input  logic [7:0] i_data,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_item      o_item
);

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_item.start     = i_start;
        o_item.data      = i_data;
        o_item.is_sync   = (i_data == SYNC_BYTE_A) || (i_data == SYNC_BYTE_B);
        o_item.is_fmt    = (i_data == FMT_SDMF) || (i_data == FMT_MDMF);
        o_item.fmt_multi = (i_data == FMT_MDMF);
    end

endmodule

[rtl/cidp_queue.sv]
// Short queue of classified bytes between the front end and the parser.
module cidp_queue
    import cidp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

`include "caller_id_fsk_message_parser_unit_defines.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `CIDP_ASSERT_NEXT(a_q_fill_grows, do_push && !do_pop, r_count == $past(r_count) + CNT_W'(1), "queue fill did not grow on a lone push")
    `CIDP_ASSERT(a_q_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH), "queue fill exceeds depth")
    `CIDP_ASSERT(a_q_ptr_gap, 1'b1, r_wr_ptr == r_rd_ptr + PTR_W'(r_count), "queue pointers disagree with fill")

endmodule

[rtl/cidp_back.sv]
// Parser back end: message state machine and registered result slot.
module cidp_back
    import cidp_pkg::*;
#(
    parameter int CAPTURE_BYTES = 128
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_kind      o_kind,
    output logic [7:0] o_digit,
    output logic       o_format_multi,
    output logic       o_last
);

`include "caller_id_fsk_message_parser_unit_defines.svh"

    localparam int PW = $clog2(CAPTURE_BYTES + 1);
    localparam int CW = ((PW > 8) ? PW : 8) + 1;

    typedef enum logic [6:0] {
        PH_SYNC   = 7'b0000001,
        PH_FORMAT = 7'b0000010,
        PH_LENGTH = 7'b0000100,
        PH_SKIP   = 7'b0001000,
        PH_NUMLEN = 7'b0010000,
        PH_DIGITS = 7'b0100000,
        PH_DONE   = 7'b1000000
    } t_phase;

    t_phase          r_phase, n_phase, e_phase;
    logic [PW-1:0]   r_pos, n_pos, e_pos;
    logic [3:0]      r_sync_run, n_sync_run, e_sync_run;
    logic            r_is_multi, n_is_multi, e_is_multi;
    logic [3:0]      r_skip_left, n_skip_left, e_skip_left;
    logic [7:0]      r_digits_left, n_digits_left, e_digits_left;

    logic            r_out_valid;
    t_kind           r_kind;
    logic [7:0]      r_digit;
    logic            r_format_multi;
    logic            r_last;

    logic            has_res;
    t_kind           res_kind;
    logic [7:0]      res_digit;
    logic            res_last;
    logic [CW-1:0]   pos_ext, pos_next, win_ext;
    logic [7:0]      sdmf_count, sdmf_sat, num_sat, digits_dec;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        if (i_q_item.start) begin
            e_phase       = PH_SYNC;
            e_pos         = '0;
            e_sync_run    = '0;
            e_is_multi    = 1'b0;
            e_skip_left   = '0;
            e_digits_left = '0;
        end else begin
            e_phase       = r_phase;
            e_pos         = r_pos;
            e_sync_run    = r_sync_run;
            e_is_multi    = r_is_multi;
            e_skip_left   = r_skip_left;
            e_digits_left = r_digits_left;
        end
    end

    always_comb begin
        pos_ext    = CW'(e_pos);
        pos_next   = pos_ext + CW'(1);
        win_ext    = CW'(i_cfg.search_window);
        sdmf_count = i_q_item.data - SDMF_TIME_LEN;
        sdmf_sat   = (sdmf_count > i_cfg.max_digits) ? i_cfg.max_digits : sdmf_count;
        num_sat    = (i_q_item.data > i_cfg.max_digits) ? i_cfg.max_digits
                                                        : i_q_item.data;
        digits_dec = e_digits_left - 8'd1;
    end

    always_comb begin
        n_phase       = e_phase;
        n_pos         = e_pos;
        n_sync_run    = e_sync_run;
        n_is_multi    = e_is_multi;
        n_skip_left   = e_skip_left;
        n_digits_left = e_digits_left;
        has_res       = 1'b0;
        res_kind      = KIND_ERROR;
        res_digit     = 8'd0;
        res_last      = 1'b1;

        // Once the capture is full, bytes change nothing but a start flag.
        if (e_pos < PW'(CAPTURE_BYTES)) begin
            n_pos = e_pos + PW'(1);
            case (e_phase)
                PH_SYNC: begin
                    if (pos_ext >= win_ext) begin
                        has_res = 1'b1;
                    end else begin
                        if (i_q_item.is_sync && (e_sync_run >= i_cfg.sync_run_min)) begin
                            n_phase = PH_FORMAT;
                        end else if (i_q_item.is_sync) begin
                            n_sync_run = e_sync_run + 4'd1;
                        end else begin
                            n_sync_run = '0;
                        end
                        if (pos_next >= win_ext) begin
                            has_res = 1'b1;
                        end
                    end
                end
                PH_FORMAT: begin
                    if (pos_ext >= win_ext) begin
                        has_res = 1'b1;
                    end else if (i_q_item.is_fmt) begin
                        n_is_multi = i_q_item.fmt_multi;
                        n_phase    = PH_LENGTH;
                    end else if (pos_next >= win_ext) begin
                        has_res = 1'b1;
                    end
                end
                PH_LENGTH: begin
                    if (e_is_multi) begin
                        if (i_q_item.data < MDMF_MIN_LEN) begin
                            has_res = 1'b1;
                        end else begin
                            n_skip_left = MDMF_SKIP;
                            n_phase     = PH_SKIP;
                        end
                    end else if (i_q_item.data < SDMF_MIN_LEN) begin
                        has_res = 1'b1;
                    end else begin
                        n_skip_left   = SDMF_SKIP;
                        n_digits_left = sdmf_sat;
                        if (sdmf_sat == 8'd0) begin
                            has_res  = 1'b1;
                            res_kind = KIND_EMPTY;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip_left = e_skip_left - 4'd1;
                    if (n_skip_left == 4'd0) begin
                        n_phase = e_is_multi ? PH_NUMLEN : PH_DIGITS;
                    end
                end
                PH_NUMLEN: begin
                    n_digits_left = num_sat;
                    if (num_sat == 8'd0) begin
                        has_res  = 1'b1;
                        res_kind = KIND_EMPTY;
                    end else begin
                        n_phase = PH_DIGITS;
                    end
                end
                PH_DIGITS: begin
                    n_digits_left = digits_dec;
                    has_res       = 1'b1;
                    res_kind      = KIND_DIGIT;
                    res_digit     = i_q_item.data;
                    res_last      = (digits_dec == 8'd0);
                end
                default: begin
                end
            endcase
            if (has_res && res_last) begin
                n_phase = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SYNC;
            r_pos         <= '0;
            r_sync_run    <= '0;
            r_is_multi    <= 1'b0;
            r_skip_left   <= '0;
            r_digits_left <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase       <= n_phase;
                r_pos         <= n_pos;
                r_sync_run    <= n_sync_run;
                r_is_multi    <= n_is_multi;
                r_skip_left   <= n_skip_left;
                r_digits_left <= n_digits_left;
                r_out_valid   <= has_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && has_res) begin
            r_kind         <= res_kind;
            r_digit        <= res_digit;
            r_format_multi <= n_is_multi;
            r_last         <= res_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_digit        = r_digit;
    assign o_format_multi = r_format_multi;
    assign o_last         = r_last;

    `CIDP_ASSERT(a_err_is_last, r_out_valid && (r_kind == KIND_ERROR), r_last, "error result without last mark")
    `CIDP_ASSERT(a_last_done, r_out_valid && r_last, r_phase == PH_DONE, "last result pending while parser not finished")
    `CIDP_ASSERT(a_mid_digit, r_out_valid && (r_kind == KIND_DIGIT) && !r_last, (r_phase == PH_DIGITS) && (r_digits_left != 8'd0), "digit pending without digits left")

endmodule

[rtl/caller_id_fsk_message_parser_unit.sv]
// Top level of the caller-ID message parser: config registers and module wiring.
// The parser accepts one demodulated caller-ID byte per clock cycle while the queue is
// not full and gives at most one result per byte. A byte passes the classifier, waits in
// a four-entry queue and is parsed by the message state machine, whose result sits in an
// output register; the queue lets input keep flowing for four bytes while the output is
// stalled. The rate of one byte per cycle is set by the state machine, which takes one
// queued byte per cycle while its output register is free. A byte with the start flag
// set clears the parser before it is parsed. Configuration registers are to be written
// through the config channel while the parser is idle; the block does not enforce this.
module caller_id_fsk_message_parser_unit
    import cidp_pkg::*;
#(
    parameter int CAPTURE_BYTES = 128
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0] s_axis_tuser,   // [0] start_capture
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] digit
    output logic [2:0] m_axis_tuser,   // [1:0] kind, [2] format_multi
    output logic       m_axis_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg   r_cfg;
    logic   queue_full, push, q_valid, q_pop;
    t_item  front_item, q_item;
    t_kind  out_kind;
    logic   out_multi;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.search_window <= RST_SEARCH_WINDOW;
            r_cfg.sync_run_min  <= RST_SYNC_RUN_MIN;
            r_cfg.max_digits    <= RST_MAX_DIGITS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEARCH_WINDOW: r_cfg.search_window <= i_cfg_data;
                CFG_SYNC_RUN_MIN:  r_cfg.sync_run_min  <= i_cfg_data[3:0];
                CFG_MAX_DIGITS:    r_cfg.max_digits    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cidp_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_start      (s_axis_tuser[0]),
        .i_data       (s_axis_tdata),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    cidp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cidp_back #(
        .CAPTURE_BYTES (CAPTURE_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_kind         (out_kind),
        .o_digit        (m_axis_tdata),
        .o_format_multi (out_multi),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tuser = {out_multi, out_kind};

endmodule
